@@ src/adc_block_average_calibrate_assert.svh @@
// Assertion macros for the block-average calibrator.
`ifndef ADC_BLOCK_AVERAGE_CALIBRATE_ASSERT_SVH
`define ADC_BLOCK_AVERAGE_CALIBRATE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ADCBAC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ADCBAC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ src/adcbac_pkg.sv @@
package adcbac_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int ANGLE_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int S_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // |(mean - raw_min) * (angle_max - angle_min)| stays below 2**28
    localparam int PROD_MAG_W = 28;
    localparam int DELTA_W    = SAMPLE_W + 1;
    localparam int SPAN_A_W   = ANGLE_W + 1;
    localparam int PROD_W     = DELTA_W + SPAN_A_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_ENABLE = 3'd0,
        CFG_RAW_MIN    = 3'd1,
        CFG_RAW_MAX    = 3'd2,
        CFG_ANGLE_MIN  = 3'd3,
        CFG_ANGLE_MAX  = 3'd4
    } t_cfg_idx;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MDIV  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CLOAD = 7'b0001000,
        S_CDIV  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

@@ src/adc_block_average_calibrate.sv @@
// Block averager with optional two-point linear calibration. Samples arrive one
// per item on the s stream and are summed in blocks of SEGMENT_LEN; after the
// last sample of a block one result leaves on the m stream: the truncated block
// mean, or with cal_enable set, angle_min + (mean-raw_min)*(angle_max-angle_min)
// / (raw_max-raw_min) with the division truncated toward zero (a zero raw span
// gives angle_min). tuser marks which of the two the result is. Every sample but
// the last of a block is accepted without a stall. The last one keeps the input
// stalled while the mean is formed by a reciprocal multiply and, when calibrating,
// while a multiply step, a load step, DIV_W = 28 steps of a restoring divider (one
// quotient bit per cycle) and a sign fix-up step run; a zero raw span skips the
// divider and the fix-up. The input stays held off through the hand-off to the
// output register, plus any wait on the output register. The result is buffered
// in one output register, so the next block's samples flow in while it waits.
// Configuration is taken at any time through the cfg port and is meant to change
// only while the block is idle; the settings at block end apply.
module adc_block_average_calibrate #(
    parameter int SEGMENT_LEN = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream, tdata: [11:0] sample, [15:12] zero
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [adcbac_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // master stream, tdata: [31:0] value
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [adcbac_pkg::VALUE_W-1:0]       o_m_tdata,
    // tuser: [0] calibrated
    output logic                                 o_m_tuser,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [adcbac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adcbac_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SUM_W  = $clog2(SEGMENT_LEN * adcbac_pkg::SAMPLE_MAX + 1);
    localparam int CNT_W  = $clog2(SEGMENT_LEN);
    localparam int DIV_W  = adcbac_pkg::PROD_MAG_W;
    localparam int DVS_W  = adcbac_pkg::SAMPLE_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int SW     = adcbac_pkg::SAMPLE_W;
    localparam int VW     = adcbac_pkg::VALUE_W;
    localparam int AW     = adcbac_pkg::ANGLE_W;
    // mean = (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for every sum below 2**SUM_W
    localparam int MEAN_SHIFT = SUM_W + $clog2(SEGMENT_LEN);
    localparam int RECIP_W    = SUM_W + 1;
    localparam int MPROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'((longint'(1) << MEAN_SHIFT) / SEGMENT_LEN + 1);

    adcbac_pkg::t_state r_state;

    // configuration registers
    logic                  r_cal_en;
    logic [SW-1:0]         r_raw_min;
    logic [SW-1:0]         r_raw_max;
    logic [AW-1:0]         r_angle_min;
    logic [AW-1:0]         r_angle_max;

    // block accumulator
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic [CNT_W-1:0]      r_count;
    logic                  last_sample;
    logic                  s_accept;

    // block mean
    logic [MPROD_W-1:0]    mean_prod;
    logic [SW-1:0]         mean_val;

    // restoring divider; r_quo also holds the block sum for the mean
    logic [DIV_W-1:0]      r_quo;
    logic [DVS_W-1:0]      r_rem;
    logic [DVS_W-1:0]      r_dvs;
    logic [STEP_W-1:0]     r_step;
    logic [DVS_W:0]        rem_sh;
    logic                  q_bit;
    logic [DVS_W-1:0]      n_rem;

    // calibration datapath
    logic [SW-1:0]                       r_mean;
    logic                                r_res_cal;
    logic signed [adcbac_pkg::PROD_W-1:0] r_prod;
    logic                                r_neg;
    logic signed [adcbac_pkg::DELTA_W-1:0]  delta;
    logic signed [adcbac_pkg::SPAN_A_W-1:0] span_ang;
    logic signed [adcbac_pkg::DELTA_W-1:0]  raw_span;
    logic [adcbac_pkg::PROD_W-1:0]       prod_abs;
    logic [adcbac_pkg::DELTA_W-1:0]      raw_span_abs;
    logic [VW-1:0]                       angle_ext;
    logic [VW-1:0]                       q_mag;
    logic [VW-1:0]                       q_signed;

    // output register
    logic                  r_out_valid;
    logic [VW-1:0]         r_out_value;
    logic                  r_out_cal;
    logic [VW-1:0]         r_res;
    logic                  out_free;

    assign o_s_tready  = (r_state == adcbac_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_value;
    assign o_m_tuser   = r_out_cal;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign last_sample = (r_count == CNT_W'(SEGMENT_LEN - 1));
    assign n_sum       = r_sum + SUM_W'(i_s_tdata[SW-1:0]);
    assign out_free    = !r_out_valid || i_m_tready;

    // divide the block total by its length through the reciprocal
    assign mean_prod = {{RECIP_W{1'b0}}, r_quo[SUM_W-1:0]} * {{SUM_W{1'b0}}, MEAN_RECIP};
    assign mean_val  = mean_prod[MEAN_SHIFT +: SW];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        if (q_bit) begin
            n_rem = DVS_W'(rem_sh - {1'b0, r_dvs});
        end else begin
            n_rem = rem_sh[DVS_W-1:0];
        end
    end

    // signed operands of the calibration line
    always_comb begin
        delta    = $signed({1'b0, r_mean}) - $signed({1'b0, r_raw_min});
        span_ang = $signed({r_angle_max[AW-1], r_angle_max})
                 - $signed({r_angle_min[AW-1], r_angle_min});
        raw_span = $signed({1'b0, r_raw_max}) - $signed({1'b0, r_raw_min});
        prod_abs = r_prod[adcbac_pkg::PROD_W-1] ? adcbac_pkg::PROD_W'(-r_prod)
                                                : adcbac_pkg::PROD_W'(r_prod);
        raw_span_abs = raw_span[adcbac_pkg::DELTA_W-1]
                     ? adcbac_pkg::DELTA_W'(-raw_span)
                     : adcbac_pkg::DELTA_W'(raw_span);
        angle_ext = {{(VW - AW){r_angle_min[AW-1]}}, r_angle_min};
        q_mag     = VW'(r_quo);
        q_signed  = r_neg ? (~q_mag + VW'(1)) : q_mag;
    end

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_en    <= 1'b0;
            r_raw_min   <= '0;
            r_raw_max   <= '0;
            r_angle_min <= '0;
            r_angle_max <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adcbac_pkg::CFG_CAL_ENABLE: r_cal_en    <= i_cfg_data[0];
                adcbac_pkg::CFG_RAW_MIN:    r_raw_min   <= i_cfg_data[SW-1:0];
                adcbac_pkg::CFG_RAW_MAX:    r_raw_max   <= i_cfg_data[SW-1:0];
                adcbac_pkg::CFG_ANGLE_MIN:  r_angle_min <= i_cfg_data[AW-1:0];
                adcbac_pkg::CFG_ANGLE_MAX:  r_angle_max <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adcbac_pkg::S_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, or drop the one just taken
            if (r_state == adcbac_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                adcbac_pkg::S_IDLE: begin
                    if (s_accept) begin
                        if (last_sample) begin
                            // close the block, divide the sum by its length
                            r_sum   <= '0;
                            r_count <= '0;
                            r_state <= adcbac_pkg::S_MDIV;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                adcbac_pkg::S_MDIV: begin
                    r_state <= r_cal_en ? adcbac_pkg::S_MUL : adcbac_pkg::S_OUT;
                end
                adcbac_pkg::S_MUL: begin
                    r_state <= adcbac_pkg::S_CLOAD;
                end
                adcbac_pkg::S_CLOAD: begin
                    r_state <= (raw_span == '0) ? adcbac_pkg::S_OUT : adcbac_pkg::S_CDIV;
                end
                adcbac_pkg::S_CDIV: begin
                    if (r_step == '0) begin
                        r_state <= adcbac_pkg::S_FIN;
                    end
                end
                adcbac_pkg::S_FIN: begin
                    r_state <= adcbac_pkg::S_OUT;
                end
                adcbac_pkg::S_OUT: begin
                    if (out_free) begin
                        r_state <= adcbac_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= adcbac_pkg::S_IDLE;
                end
            endcase
        end
    end

    // datapath: mean, multiplier, divider, result and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            adcbac_pkg::S_IDLE: begin
                if (s_accept && last_sample) begin
                    r_quo <= DIV_W'(n_sum);
                end
            end
            adcbac_pkg::S_MDIV: begin
                r_mean    <= mean_val;
                r_res     <= VW'(mean_val);
                r_res_cal <= r_cal_en;
            end
            adcbac_pkg::S_MUL: begin
                r_prod <= delta * span_ang;
            end
            adcbac_pkg::S_CLOAD: begin
                r_quo  <= DIV_W'(prod_abs);
                r_rem  <= '0;
                r_dvs  <= DVS_W'(raw_span_abs);
                r_neg  <= r_prod[adcbac_pkg::PROD_W-1] ^ raw_span[adcbac_pkg::DELTA_W-1];
                r_step <= STEP_W'(DIV_W - 1);
                r_res  <= angle_ext;
            end
            adcbac_pkg::S_CDIV: begin
                r_quo  <= {r_quo[DIV_W-2:0], q_bit};
                r_rem  <= n_rem;
                r_step <= r_step - STEP_W'(1);
            end
            adcbac_pkg::S_FIN: begin
                r_res <= angle_ext + q_signed;
            end
            adcbac_pkg::S_OUT: begin
                if (out_free) begin
                    r_out_value <= r_res;
                    r_out_cal   <= r_res_cal;
                end
            end
            default: ;
        endcase
    end

`include "adc_block_average_calibrate_assert.svh"

    // the partial remainder never reaches the divisor while dividing
    `ADCBAC_ASSERT_NOW(a_rem_below_dvs, i_clk, i_rst_n, (r_state == adcbac_pkg::S_CDIV), (r_rem < r_dvs), "divider remainder not below divisor")
    // the last sample of a block starts the mean division
    `ADCBAC_ASSERT_NEXT(a_block_to_div, i_clk, i_rst_n, (s_accept && last_sample), (r_state == adcbac_pkg::S_MDIV && r_sum == '0), "block end did not start division")
    // a result appears only from the hand-off state
    `ADCBAC_ASSERT_NOW(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == adcbac_pkg::S_OUT), "result valid without hand-off")

endmodule
